>>> design/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared constants, types and helpers for the fit-policy bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

  // Bitmap geometry
  localparam int ENTRIES = 1024;
  localparam int ROW_W   = 8;                  // bits per bitmap row
  localparam int ROWS    = ENTRIES / ROW_W;
  localparam int ROW_AW  = $clog2(ROWS);
  localparam int BIT_AW  = $clog2(ROW_W);
  localparam int IDX_W   = 10;                 // entry index field
  localparam int CNT_W   = 11;                 // counts, limit, free count

  // Fit modes
  localparam logic [1:0] MODE_FIRST  = 2'd0;
  localparam logic [1:0] MODE_BEST   = 2'd1;
  localparam logic [1:0] MODE_WORST  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;   // no policy: allocate fails

  // Commands
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_MARK  = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  // Register indexes
  localparam logic REG_FIT_MODE = 1'b0;
  localparam logic REG_ENTRIES  = 1'b1;

  // Control from the sequencer to the run unit
  typedef struct packed {
    logic clear;   // start of a scan: drop all run and count state
    logic step;    // a bitmap row is on the data inputs
    logic close;   // end of scan: close a run still open
  } run_ctl_t;

  // Results of the run unit
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] pick;
    logic [CNT_W-1:0] free_total;
  } run_res_t;

  // True when a run of length len should replace the current choice.
  function automatic logic run_better(input logic             found,
                                      input logic [1:0]       mode,
                                      input logic [CNT_W-1:0] len,
                                      input logic [CNT_W-1:0] best_len);
    logic r;
    r = !found ||
        ((mode == MODE_BEST)  && (len < best_len)) ||
        ((mode == MODE_WORST) && (len > best_len));
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/fit_policy_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// fit_policy_bitmap_allocator_top
// Bitmap allocator with first, best and worst fit over up to 1024 entries.
// ----------------------------------------------------------------------------
// One item at a time. The bitmap lives in a 128 x 8 memory and every scan
// reads one row per cycle through a single shared run unit. An allocate
// scans all 128 rows, closes a run still open after the last one, then
// picks, reads and writes the row and hands the result to the result
// register. Free, mark and query of an index inside the managed range are a
// read-modify-write of one row; an index outside it fails. An allocate
// with fit mode 3 fails without a scan. After reset a clearing pass writes
// zeros into all 128 rows while in_tready stays low. Writing
// entries_in_use starts a recount scan that holds in_tready low until it
// ends; a further write of that register during the recount restarts it.
// fit_mode takes effect at once, also on an allocate scan already running.
// The result register lets a new beat be accepted while the last result
// beat still waits on out_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_policy_bitmap_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command beats: [1:0] command, [11:2] entry_index, [15:12] zero
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,
  // result beats: [0] success, [10:1] result_index, [11] entry_used,
  // [22:12] free_count, [23] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,
  // register writes
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_wdata
);

  localparam int CW = fpba_pkg::CNT_W;
  localparam int IW = fpba_pkg::IDX_W;
  localparam int AW = fpba_pkg::ROW_AW;
  localparam int RW = fpba_pkg::ROW_W;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;  // zero the bitmap after reset
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;  // row-by-row scan through run unit
  localparam logic [2:0] S_POST  = 3'd3;  // scan result is ready
  localparam logic [2:0] S_RD    = 3'd4;  // read target row
  localparam logic [2:0] S_WR    = 3'd5;  // update bit, write row back
  localparam logic [2:0] S_RESP  = 3'd6;  // hand result to output register

  logic [2:0]    state_r,      state_nxt;
  logic [AW-1:0] clr_addr_r,   clr_addr_nxt;
  logic          pend_r,       pend_nxt;      // recount owed
  logic [1:0]    mode_r,       mode_nxt;
  logic [CW-1:0] entries_r,    entries_nxt;
  logic [CW-1:0] free_r,       free_nxt;
  logic [1:0]    cmd_r,        cmd_nxt;
  logic [IW-1:0] tgt_r,        tgt_nxt;
  logic          recount_r,    recount_nxt;   // scan is a recount
  logic [AW:0]   scan_cnt_r,   scan_cnt_nxt;
  logic          step_vld_r,   step_vld_nxt;
  logic [AW-1:0] step_addr_r,  step_addr_nxt;
  logic          res_ok_r,     res_ok_nxt;
  logic [IW-1:0] res_idx_r,    res_idx_nxt;
  logic          res_used_r,   res_used_nxt;
  logic          out_valid_r,  out_valid_nxt;
  logic          out_ok_r,     out_ok_nxt;
  logic [IW-1:0] out_idx_r,    out_idx_nxt;
  logic          out_used_r,   out_used_nxt;
  logic [CW-1:0] out_free_r,   out_free_nxt;

  // bitmap memory
  logic [RW-1:0] mem [fpba_pkg::ROWS];
  logic [RW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [RW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  fpba_pkg::run_ctl_t run_ctl;
  fpba_pkg::run_res_t run_res;

  logic [CW-1:0]     lim;
  logic              in_acc;
  logic [1:0]        in_cmd;
  logic [IW-1:0]     in_idx;
  logic              old_bit;
  logic              new_bit;
  logic [RW-1:0]     row_new;
  logic              scan_done;

  assign in_cmd = in_tdata[1:0];
  assign in_idx = in_tdata[11:2];
  assign lim    = (entries_r > CW'(fpba_pkg::ENTRIES)) ? CW'(fpba_pkg::ENTRIES) : entries_r;

  assign in_tready = (state_r == S_IDLE) && !pend_r;
  assign in_acc    = in_tvalid && in_tready;

  // all rows issued and the last one stepped
  assign scan_done = scan_cnt_r[AW] && !step_vld_r;

  // read-modify-write of the target bit
  always_comb begin
    old_bit = rdata_r[tgt_r[fpba_pkg::BIT_AW-1:0]];
    case (cmd_r)
      fpba_pkg::CMD_ALLOC: new_bit = 1'b1;
      fpba_pkg::CMD_MARK:  new_bit = 1'b1;
      fpba_pkg::CMD_FREE:  new_bit = 1'b0;
      fpba_pkg::CMD_QUERY: new_bit = old_bit;
      default:             new_bit = old_bit;
    endcase
    row_new = rdata_r;
    row_new[tgt_r[fpba_pkg::BIT_AW-1:0]] = new_bit;
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tgt_r[IW-1:fpba_pkg::BIT_AW];
    mem_wdata = row_new;
    mem_raddr = tgt_r[IW-1:fpba_pkg::BIT_AW];
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      S_SCAN:  mem_raddr = scan_cnt_r[AW-1:0];
      S_WR:    mem_we    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // run unit control
  always_comb begin
    run_ctl.clear = 1'b0;
    run_ctl.step  = (state_r == S_SCAN) && step_vld_r;
    run_ctl.close = (state_r == S_SCAN) && scan_done;
    if (state_r == S_IDLE) begin
      run_ctl.clear = pend_r || (in_acc && (in_cmd == fpba_pkg::CMD_ALLOC));
    end
  end

  fpba_run_unit u_run (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (run_ctl),
    .mode     (mode_r),
    .lim      (lim),
    .row_addr (step_addr_r),
    .row_data (rdata_r),
    .res      (run_res)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    pend_nxt      = pend_r;
    mode_nxt      = mode_r;
    entries_nxt   = entries_r;
    free_nxt      = free_r;
    cmd_nxt       = cmd_r;
    tgt_nxt       = tgt_r;
    recount_nxt   = recount_r;
    scan_cnt_nxt  = scan_cnt_r;
    step_vld_nxt  = 1'b0;
    step_addr_nxt = scan_cnt_r[AW-1:0];
    res_ok_nxt    = res_ok_r;
    res_idx_nxt   = res_idx_r;
    res_used_nxt  = res_used_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_idx_nxt   = out_idx_r;
    out_used_nxt  = out_used_r;
    out_free_nxt  = out_free_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(fpba_pkg::ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pend_r) begin
          recount_nxt  = 1'b1;
          scan_cnt_nxt = '0;
          state_nxt    = S_SCAN;
        end else if (in_acc) begin
          cmd_nxt = in_cmd;
          tgt_nxt = in_idx;
          if (in_cmd == fpba_pkg::CMD_ALLOC) begin
            if (mode_r == fpba_pkg::MODE_UNUSED) begin
              // unused mode: fail, nothing changes
              res_ok_nxt   = 1'b0;
              res_idx_nxt  = '0;
              res_used_nxt = 1'b0;
              state_nxt    = S_RESP;
            end else begin
              recount_nxt  = 1'b0;
              scan_cnt_nxt = '0;
              state_nxt    = S_SCAN;
            end
          end else if ({1'b0, in_idx} < lim) begin
            state_nxt = S_RD;
          end else begin
            res_ok_nxt   = 1'b0;
            res_idx_nxt  = in_idx;
            res_used_nxt = 1'b0;
            state_nxt    = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (!scan_cnt_r[AW]) begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
          step_vld_nxt = 1'b1;
        end
        if (scan_done) begin
          state_nxt = S_POST;
        end
        // a new limit during a recount makes it stale: start over
        if (recount_r && cfg_we && (cfg_index == fpba_pkg::REG_ENTRIES)) begin
          state_nxt = S_IDLE;
        end
      end
      S_POST: begin
        if (recount_r) begin
          free_nxt  = run_res.free_total;
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else if (run_res.found) begin
          tgt_nxt   = run_res.pick;
          state_nxt = S_RD;
        end else begin
          res_ok_nxt   = 1'b0;
          res_idx_nxt  = '0;
          res_used_nxt = 1'b0;
          state_nxt    = S_RESP;
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        case (cmd_r)
          fpba_pkg::CMD_ALLOC: begin
            if (free_r != '0) begin
              free_nxt = free_r - 1'b1;
            end
          end
          fpba_pkg::CMD_MARK: begin
            if (!old_bit && (free_r != '0)) begin
              free_nxt = free_r - 1'b1;
            end
          end
          fpba_pkg::CMD_FREE: begin
            if (old_bit) begin
              free_nxt = free_r + 1'b1;
            end
          end
          default: ;
        endcase
        res_ok_nxt   = 1'b1;
        res_idx_nxt  = tgt_r;
        res_used_nxt = new_bit;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_idx_nxt   = res_idx_r;
          out_used_nxt  = res_used_r;
          out_free_nxt  = free_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // register writes
    if (cfg_we) begin
      case (cfg_index)
        fpba_pkg::REG_FIT_MODE: mode_nxt = cfg_wdata[1:0];
        fpba_pkg::REG_ENTRIES: begin
          entries_nxt = cfg_wdata;
          pend_nxt    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      mode_r      <= fpba_pkg::MODE_FIRST;
      entries_r   <= CW'(fpba_pkg::ENTRIES);
      free_r      <= CW'(fpba_pkg::ENTRIES);
      recount_r   <= 1'b0;
      scan_cnt_r  <= '0;
      step_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pend_r      <= pend_nxt;
      mode_r      <= mode_nxt;
      entries_r   <= entries_nxt;
      free_r      <= free_nxt;
      recount_r   <= recount_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      step_vld_r  <= step_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    tgt_r       <= tgt_nxt;
    step_addr_r <= step_addr_nxt;
    res_ok_r    <= res_ok_nxt;
    res_idx_r   <= res_idx_nxt;
    res_used_r  <= res_used_nxt;
    out_ok_r    <= out_ok_nxt;
    out_idx_r   <= out_idx_nxt;
    out_used_r  <= out_used_nxt;
    out_free_r  <= out_free_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_free_r, out_used_r, out_idx_r, out_ok_r};

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("block still ready after taking a command beat");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> ({1'b0, tgt_r} < lim))
    else $error("bitmap write outside the managed range");

  a_fail_not_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> !out_used_r)
    else $error("failed result reports a used entry");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_CLEAR) && !in_tready)
    else $error("no clearing pass after reset");

endmodule

`default_nettype wire

>>> design/fpba_run_unit.sv
// ----------------------------------------------------------------------------
// fpba_run_unit
// Shared scan unit: takes one bitmap row per step, tracks free runs under the
// fit policy and counts free managed entries.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_run_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fpba_pkg::run_ctl_t            ctl,
  input  wire logic [1:0]                    mode,
  input  wire logic [fpba_pkg::CNT_W-1:0]    lim,
  input  wire logic [fpba_pkg::ROW_AW-1:0]   row_addr,
  input  wire logic [fpba_pkg::ROW_W-1:0]    row_data,
  output fpba_pkg::run_res_t                 res
);

  logic [fpba_pkg::CNT_W-1:0] cur_len_r,    cur_len_nxt;
  logic [fpba_pkg::IDX_W-1:0] cur_start_r,  cur_start_nxt;
  logic [fpba_pkg::CNT_W-1:0] best_len_r,   best_len_nxt;
  logic [fpba_pkg::IDX_W-1:0] best_start_r, best_start_nxt;
  logic                       found_r,      found_nxt;
  logic [fpba_pkg::CNT_W-1:0] pop_r,        pop_nxt;

  always_comb begin
    logic [fpba_pkg::IDX_W-1:0] g;
    logic                       f;
    cur_len_nxt    = cur_len_r;
    cur_start_nxt  = cur_start_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    found_nxt      = found_r;
    pop_nxt        = pop_r;
    g              = '0;
    f              = 1'b0;
    if (ctl.clear) begin
      cur_len_nxt    = '0;
      cur_start_nxt  = '0;
      best_len_nxt   = '0;
      best_start_nxt = '0;
      found_nxt      = 1'b0;
      pop_nxt        = '0;
    end else if (ctl.step) begin
      // walk the row low bit first; entries at or above the limit act as used
      for (int j = 0; j < fpba_pkg::ROW_W; j++) begin
        g = {row_addr, fpba_pkg::BIT_AW'(j)};
        f = !row_data[j] && ({1'b0, g} < lim);
        if (f) begin
          if (cur_len_nxt == '0) begin
            cur_start_nxt = g;
          end
          cur_len_nxt = cur_len_nxt + 1'b1;
          pop_nxt     = pop_nxt + 1'b1;
        end else if (cur_len_nxt != '0) begin
          if (fpba_pkg::run_better(found_nxt, mode, cur_len_nxt, best_len_nxt)) begin
            found_nxt      = 1'b1;
            best_len_nxt   = cur_len_nxt;
            best_start_nxt = cur_start_nxt;
          end
          cur_len_nxt = '0;
        end
      end
    end else if (ctl.close) begin
      if (cur_len_r != '0) begin
        if (fpba_pkg::run_better(found_r, mode, cur_len_r, best_len_r)) begin
          found_nxt      = 1'b1;
          best_len_nxt   = cur_len_r;
          best_start_nxt = cur_start_r;
        end
        cur_len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_len_r <= '0;
      found_r   <= 1'b0;
    end else begin
      cur_len_r <= cur_len_nxt;
      found_r   <= found_nxt;
    end
    cur_start_r  <= cur_start_nxt;
    best_len_r   <= best_len_nxt;
    best_start_r <= best_start_nxt;
    pop_r        <= pop_nxt;
  end

  assign res.found      = found_r;
  assign res.pick       = best_start_r;
  assign res.free_total = pop_r;

endmodule

`default_nettype wire

>>> dv/fit_policy_bitmap_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// fit_policy_bitmap_allocator_top_tb
// Self-checking bench for the first/best/worst fit bitmap allocator.
// ----------------------------------------------------------------------------
// A shadow bitmap and free count predict every result beat. A short directed
// sequence hits reset state, the whole-map best-fit run, redundant free and
// mark, index 1023, a zero limit, fit mode 3 and a limit above 1024. Random
// phases follow, mostly on small managed ranges so that the map fills,
// fragments and runs out. Stream idling is swapped between the two sides
// and then dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module fit_policy_bitmap_allocator_top_tb;

  // Cycles to let a scan or recount settle before a register write
  localparam int SCAN_SETTLE = 160;

  // Result beat layout, lowest bit last
  typedef struct packed {
    logic                       pad;
    logic [fpba_pkg::CNT_W-1:0] free_count;
    logic                       entry_used;
    logic [fpba_pkg::IDX_W-1:0] result_index;
    logic                       success;
  } alloc_result_t;

  // --------------------------------------------------------------------------
  // Allocation predictor and result store
  // --------------------------------------------------------------------------
  class alloc_scoreboard;
    bit [fpba_pkg::ENTRIES-1:0] used_map;
    int unsigned                free_cnt;
    logic [1:0]                 mode;
    int unsigned                limit_reg;
    alloc_result_t              expected_q[$];
    int unsigned                failures;

    function new();
      used_map  = '0;
      mode      = fpba_pkg::MODE_FIRST;
      limit_reg = 1024;
      free_cnt  = 1024;
      failures  = 0;
    endfunction

    function int unsigned managed();
      return (limit_reg > fpba_pkg::ENTRIES) ? fpba_pkg::ENTRIES : limit_reg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Register write; a new limit recounts free entries over the new range,
    // bits above it keep their value
    function void apply_reg(logic idx, logic [10:0] val);
      int unsigned n;
      n = 0;
      if (idx == fpba_pkg::REG_FIT_MODE) begin
        mode = val[1:0];
      end else begin
        limit_reg = 32'(val);
        for (int i = 0; i < managed(); i++)
          if (!used_map[i]) n++;
        free_cnt = n;
      end
    endfunction

    // Fit policy search; ties keep the lower run
    function bit find_free(output int unsigned pick);
      int unsigned lim, i, start, len, best_len;
      bit found;
      lim      = managed();
      i        = 0;
      found    = 0;
      best_len = 0;
      pick     = 0;
      if (mode == fpba_pkg::MODE_FIRST) begin
        for (int k = 0; k < lim; k++)
          if (!used_map[k]) begin
            pick = k;
            return 1'b1;
          end
        return 1'b0;
      end
      if (mode != fpba_pkg::MODE_BEST && mode != fpba_pkg::MODE_WORST) return 1'b0;
      while (i < lim) begin
        if (used_map[i]) begin
          i++;
        end else begin
          start = i;
          len   = 0;
          while (i < lim && !used_map[i]) begin
            len++;
            i++;
          end
          if (!found || (mode == fpba_pkg::MODE_BEST && len < best_len) ||
              (mode == fpba_pkg::MODE_WORST && len > best_len)) begin
            found    = 1'b1;
            best_len = len;
            pick     = start;
          end
        end
      end
      return found;
    endfunction

    function void note_command(logic [1:0] cmd, logic [fpba_pkg::IDX_W-1:0] idx);
      alloc_result_t r;
      int unsigned   pick;
      r = '0;
      if (cmd == fpba_pkg::CMD_ALLOC) begin
        if (find_free(pick)) begin
          used_map[pick] = 1'b1;
          if (free_cnt > 0) free_cnt--;
          r.success      = 1'b1;
          r.result_index = pick[fpba_pkg::IDX_W-1:0];
          r.entry_used   = 1'b1;
        end
      end else begin
        r.result_index = idx;
        if (idx < managed()) begin
          r.success = 1'b1;
          if (cmd == fpba_pkg::CMD_FREE && used_map[idx]) begin
            used_map[idx] = 1'b0;
            free_cnt++;
          end else if (cmd == fpba_pkg::CMD_MARK && !used_map[idx]) begin
            used_map[idx] = 1'b1;
            if (free_cnt > 0) free_cnt--;
          end
          r.entry_used = used_map[idx];
        end
      end
      r.free_count = free_cnt[fpba_pkg::CNT_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [23:0] raw);
      alloc_result_t got, want;
      got = raw;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("%0t: result beat %h with none expected", $time, raw);
        return;
      end
      want = expected_q.pop_front();
      if (got.success !== want.success || got.result_index !== want.result_index ||
          got.entry_used !== want.entry_used || got.free_count !== want.free_count) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch ok/idx/used/free exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   $time, want.success, want.result_index, want.entry_used,
                   want.free_count, got.success, got.result_index, got.entry_used,
                   got.free_count);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input known from time zero
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [1:0] command, [11:2] entry_index, [15:12] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [0] success, [10:1] result_index, [11] entry_used,
                                  // [22:12] free_count, [23] zero
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [10:0] cfg_wdata  = '0;

  fit_policy_bitmap_allocator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  alloc_scoreboard sb;

  // Idle odds in percent per cycle, and the receiver's long hold-off counter
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #(20_000_000);
    $display("Verification failed");
    $finish;
  end

  // Receiver: random backpressure, or a counted hold-off when one is asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Beat monitors, sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_command(in_tdata[1:0], in_tdata[11:2]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------

  // Offer one command beat, with random idle cycles ahead of it
  task automatic send_command(input logic [1:0] cmd,
                              input logic [fpba_pkg::IDX_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, idx, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait for every expected result beat
  task automatic wait_results;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Block fully idle: all results back, then room for any scan to finish
  task automatic settle;
    wait_results();
    repeat (SCAN_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [10:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.apply_reg(idx, val);
  endtask

  task automatic reprogram(input logic [1:0] mode, input logic [10:0] lim);
    settle();
    write_reg(fpba_pkg::REG_FIT_MODE, {9'b0, mode});
    write_reg(fpba_pkg::REG_ENTRIES, lim);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random phase: allocate-heavy mix, indexes mostly inside the managed range
  task automatic run_phase(input logic [1:0] mode, input logic [10:0] lim, input int count,
                           input int hold);
    int unsigned r, span;
    logic [1:0]  cmd;
    logic [9:0]  idx;
    reprogram(mode, lim);
    hold_left = hold;   // receiver stalls while the sender keeps pushing
    span = (32'(lim) > fpba_pkg::ENTRIES) ? fpba_pkg::ENTRIES : 32'(lim);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45)      cmd = fpba_pkg::CMD_ALLOC;
      else if (r < 75) cmd = fpba_pkg::CMD_FREE;
      else if (r < 88) cmd = fpba_pkg::CMD_MARK;
      else             cmd = fpba_pkg::CMD_QUERY;
      if (span > 0 && $urandom_range(99) < 85) idx = 10'($urandom_range(span - 1));
      else                                     idx = 10'($urandom_range(1023));
      if (n == count / 2) wait_results();   // sender pause until fully drained
      send_command(cmd, idx);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    send_idle_pct = 13;
    recv_idle_pct = 76;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // clearing pass keeps in_tready low after reset
    do @(posedge clk); while (!in_tready);

    // Directed: reset free count, then best fit over a fully free map
    send_command(fpba_pkg::CMD_QUERY, 10'd0);
    reprogram(fpba_pkg::MODE_BEST, 11'd1024);
    send_command(fpba_pkg::CMD_ALLOC, 10'd0);

    // First fit, redundant free and mark, top index
    reprogram(fpba_pkg::MODE_FIRST, 11'd1024);
    send_command(fpba_pkg::CMD_ALLOC, 10'd0);
    send_command(fpba_pkg::CMD_QUERY, 10'd0);
    send_command(fpba_pkg::CMD_FREE, 10'd0);
    send_command(fpba_pkg::CMD_FREE, 10'd0);
    send_command(fpba_pkg::CMD_MARK, 10'd1023);
    send_command(fpba_pkg::CMD_MARK, 10'd1023);
    send_command(fpba_pkg::CMD_QUERY, 10'd1023);
    send_command(fpba_pkg::CMD_FREE, 10'd1023);
    send_command(fpba_pkg::CMD_ALLOC, 10'd0);
    send_command(fpba_pkg::CMD_MARK, 10'd5);

    // Map is now used at 0, 1, 5: worst fit picks 6, best fit picks 2
    reprogram(fpba_pkg::MODE_WORST, 11'd1024);
    send_command(fpba_pkg::CMD_ALLOC, 10'd0);
    reprogram(fpba_pkg::MODE_BEST, 11'd1024);
    send_command(fpba_pkg::CMD_ALLOC, 10'd0);

    // Zero limit: nothing is managed, every command fails
    reprogram(fpba_pkg::MODE_FIRST, 11'd0);
    send_command(fpba_pkg::CMD_ALLOC, 10'd0);
    send_command(fpba_pkg::CMD_QUERY, 10'd0);
    send_command(fpba_pkg::CMD_FREE, 10'd1023);

    // Fit mode 3 fails allocation; one-entry range still answers queries
    reprogram(fpba_pkg::MODE_UNUSED, 11'd1);
    send_command(fpba_pkg::CMD_ALLOC, 10'd0);
    send_command(fpba_pkg::CMD_QUERY, 10'd0);

    // Limit above the map size is capped
    reprogram(fpba_pkg::MODE_WORST, 11'd2047);
    send_command(fpba_pkg::CMD_ALLOC, 10'd0);
    send_command(fpba_pkg::CMD_QUERY, 10'd1023);

    // Random, receiver slow; first phase opens with a long hold-off
    run_phase(fpba_pkg::MODE_BEST, 11'd16, 130, 600);
    run_phase(fpba_pkg::MODE_WORST, 11'd16, 130, 0);
    run_phase(fpba_pkg::MODE_FIRST, 11'd1, 40, 0);
    run_phase(fpba_pkg::MODE_BEST, 11'd40, 140, 0);

    // Random, sender slow
    send_idle_pct = 76;
    recv_idle_pct = 13;
    run_phase(fpba_pkg::MODE_WORST, 11'd33, 130, 0);
    run_phase(fpba_pkg::MODE_UNUSED, 11'd12, 20, 0);
    run_phase(fpba_pkg::MODE_BEST, 11'd8, 120, 0);
    run_phase(fpba_pkg::MODE_FIRST, 11'd2047, 60, 0);

    // Random, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(fpba_pkg::MODE_WORST, 11'd1024, 80, 0);
    run_phase(fpba_pkg::MODE_BEST, 11'd24, 130, 0);
    run_phase(fpba_pkg::MODE_WORST, 11'd24, 100, 0);

    settle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
